// ----- hw/rtl/rrb_pkg.sv -----
package rrb_pkg;

  // Default number of fraction bits of the blend weight.
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned RATIO_W = 16;
  localparam int unsigned IN_DATA_W  = 6 * CHAN_W + 2 * RATIO_W;
  localparam int unsigned OUT_DATA_W = 3 * CHAN_W;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // Everything but the quotient that travels with an item through the divider stages.
  typedef struct packed {
    rgb_t               base;
    rgb_t               mix;
    logic [RATIO_W-1:0] den;
    logic [RATIO_W-1:0] rem;
    logic               err;  // denominator is zero
    logic               sat;  // numerator at or above denominator, weight is one
  } div_ctl_t;

endpackage

// ----- hw/rtl/rgb_ratio_blend_unit.sv -----
// Blends two RGB888 colors by the ratio num/den, the share of the secondary color.
// Input channel (s_axis): one item holds a primary color, a secondary color and
// the ratio. Output channel (m_axis): one blended color per item, with an error
// flag in tuser that is set when the denominator was zero.
// The weight w = floor((num << FRACTION_BITS) / den) is formed by a pipelined
// restoring divider, one quotient bit per stage. A numerator at or above the
// denominator, or a zero denominator, gives the full weight, so the result is
// the secondary color. Three channel lanes then multiply in parallel and the
// output register merges them into one result item.
// An accepted item passes the divider stages, the lane stage and the output
// register, in that order. Throughput is one item per cycle while the
// receiver does not stall the output.
// Every stage has its own valid bit, so a stalled receiver only holds the
// stages that are full; empty stages further up keep taking items, and
// s_axis_tready_o drops only when the whole pipeline is full.
// Reset clears all valid bits; no item is held across reset.
module rgb_ratio_blend_unit #(
  parameter int unsigned FRACTION_BITS = rrb_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // base_red, base_green, base_blue, mix_red, mix_green, mix_blue,
  // ratio_numerator, ratio_denominator
  input  logic [rrb_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_red, out_green, out_blue
  output logic [rrb_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // ratio_error
  output logic                              m_axis_tuser_o
);

  localparam int unsigned CW = rrb_pkg::CHAN_W;
  localparam int unsigned RW = rrb_pkg::RATIO_W;
  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  // Stage index 0 .. FRACTION_BITS-1 are divider steps, FRACTION_BITS is the lane stage.
  logic [FRACTION_BITS:0]   valid_q, valid_d;
  logic [FRACTION_BITS+1:0] en;
  logic                     out_valid_q, out_valid_d;

  rrb_pkg::div_ctl_t        div_ctl  [FRACTION_BITS+1];
  logic [FRACTION_BITS-1:0] div_quot [FRACTION_BITS+1];
  rrb_pkg::div_ctl_t        in_ctl;
  logic [RW-1:0]            in_num;

  logic [FRACTION_BITS:0]   weight;
  logic                     lane_err_q;
  rrb_pkg::rgb_t            lane_rgb;
  rrb_pkg::rgb_t            out_rgb_q;
  logic                     out_err_q;

  // A stage may load when it is empty or when its contents move on.
  assign en[FRACTION_BITS+1] = !out_valid_q || m_axis_tready_i;
  for (genvar i = 0; i <= FRACTION_BITS; i++) begin : g_en
    assign en[i] = !valid_q[i] || en[i+1];
  end

  assign s_axis_tready_o = en[0];

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = s_axis_tvalid_i;
    end
    for (int i = 1; i <= FRACTION_BITS; i++) begin
      if (en[i]) begin
        valid_d[i] = valid_q[i-1];
      end
    end
    out_valid_d = en[FRACTION_BITS+1] ? valid_q[FRACTION_BITS] : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Unpack the incoming item; the saturation test also covers a zero denominator.
  assign in_num = s_axis_tdata_i[6*CW +: RW];

  always_comb begin
    in_ctl.base.red   = s_axis_tdata_i[0*CW +: CW];
    in_ctl.base.green = s_axis_tdata_i[1*CW +: CW];
    in_ctl.base.blue  = s_axis_tdata_i[2*CW +: CW];
    in_ctl.mix.red    = s_axis_tdata_i[3*CW +: CW];
    in_ctl.mix.green  = s_axis_tdata_i[4*CW +: CW];
    in_ctl.mix.blue   = s_axis_tdata_i[5*CW +: CW];
    in_ctl.den        = s_axis_tdata_i[6*CW+RW +: RW];
    in_ctl.rem        = in_num;
    in_ctl.err        = (s_axis_tdata_i[6*CW+RW +: RW] == '0);
    in_ctl.sat        = (in_num >= s_axis_tdata_i[6*CW+RW +: RW]);
  end

  assign div_ctl[0]  = in_ctl;
  assign div_quot[0] = '0;

  for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_div
    rrb_div_step #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_step (
      .clk_i  (clk_i),
      .en_i   (en[i]),
      .ctl_i  (div_ctl[i]),
      .quot_i (div_quot[i]),
      .ctl_o  (div_ctl[i+1]),
      .quot_o (div_quot[i+1])
    );
  end

  // The quotient is below one when it is used; saturated items take the full weight.
  assign weight = div_ctl[FRACTION_BITS].sat ? ONE : {1'b0, div_quot[FRACTION_BITS]};

  rrb_lane #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lane_red (
    .clk_i    (clk_i),
    .en_i     (en[FRACTION_BITS]),
    .base_i   (div_ctl[FRACTION_BITS].base.red),
    .mix_i    (div_ctl[FRACTION_BITS].mix.red),
    .weight_i (weight),
    .chan_o   (lane_rgb.red)
  );

  rrb_lane #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lane_green (
    .clk_i    (clk_i),
    .en_i     (en[FRACTION_BITS]),
    .base_i   (div_ctl[FRACTION_BITS].base.green),
    .mix_i    (div_ctl[FRACTION_BITS].mix.green),
    .weight_i (weight),
    .chan_o   (lane_rgb.green)
  );

  rrb_lane #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lane_blue (
    .clk_i    (clk_i),
    .en_i     (en[FRACTION_BITS]),
    .base_i   (div_ctl[FRACTION_BITS].base.blue),
    .mix_i    (div_ctl[FRACTION_BITS].mix.blue),
    .weight_i (weight),
    .chan_o   (lane_rgb.blue)
  );

  // The error flag rides alongside the lane products.
  always_ff @(posedge clk_i) begin
    if (en[FRACTION_BITS]) begin
      lane_err_q <= div_ctl[FRACTION_BITS].err;
    end
  end

  // Merge stage: the three lane results and the flag form the result item.
  always_ff @(posedge clk_i) begin
    if (en[FRACTION_BITS+1]) begin
      out_rgb_q <= lane_rgb;
      out_err_q <= lane_err_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_rgb_q.blue, out_rgb_q.green, out_rgb_q.red};
  assign m_axis_tuser_o  = out_err_q;

`ifndef SYNTHESIS
  // A zero denominator must always take the saturated path.
  a_err_implies_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[FRACTION_BITS-1] && div_ctl[FRACTION_BITS].err |-> div_ctl[FRACTION_BITS].sat)
    else $error("zero denominator reached the lanes without saturation");

  // The divider remainder stays below the divisor for items that use the quotient.
  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[FRACTION_BITS-1] && !div_ctl[FRACTION_BITS].sat
      |-> div_ctl[FRACTION_BITS].rem < div_ctl[FRACTION_BITS].den)
    else $error("divider remainder out of range");

  // A full lane stage behind a stalled output must not lose its item.
  a_lane_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[FRACTION_BITS] && out_valid_q && !m_axis_tready_i |=> valid_q[FRACTION_BITS])
    else $error("lane stage dropped an item during a stall");
`endif

endmodule

// ----- hw/rtl/rrb_div_step.sv -----
module rrb_div_step #(
  parameter int unsigned FRACTION_BITS = rrb_pkg::FRACTION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  rrb_pkg::div_ctl_t        ctl_i,
  input  logic [FRACTION_BITS-1:0] quot_i,
  output rrb_pkg::div_ctl_t        ctl_o,
  output logic [FRACTION_BITS-1:0] quot_o
);

  logic [rrb_pkg::RATIO_W:0]   trial;
  logic [rrb_pkg::RATIO_W:0]   diff;
  logic                        ge;
  rrb_pkg::div_ctl_t           ctl_d, ctl_q;
  logic [FRACTION_BITS-1:0]    quot_d, quot_q;

  // One restoring division step: shift the remainder, try to take off the divisor.
  always_comb begin
    trial  = {ctl_i.rem, 1'b0};
    diff   = trial - {1'b0, ctl_i.den};
    ge     = (trial >= {1'b0, ctl_i.den});
    ctl_d  = ctl_i;
    ctl_d.rem = ge ? diff[rrb_pkg::RATIO_W-1:0] : trial[rrb_pkg::RATIO_W-1:0];
    quot_d = {quot_i[FRACTION_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q  <= ctl_d;
      quot_q <= quot_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign quot_o = quot_q;

endmodule

// ----- hw/rtl/rrb_lane.sv -----
module rrb_lane #(
  parameter int unsigned FRACTION_BITS = rrb_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [rrb_pkg::CHAN_W-1:0]  base_i,
  input  logic [rrb_pkg::CHAN_W-1:0]  mix_i,
  input  logic [FRACTION_BITS:0]      weight_i,
  output logic [rrb_pkg::CHAN_W-1:0]  chan_o
);

  localparam int unsigned PW = FRACTION_BITS + rrb_pkg::CHAN_W + 3;

  logic signed [rrb_pkg::CHAN_W:0]    diff_s;
  logic signed [FRACTION_BITS+1:0]    wt_s;
  logic signed [PW-1:0]               prod_d, prod_q;
  logic [rrb_pkg::CHAN_W-1:0]         base_q;
  logic signed [PW-1:0]               sum;

  // base*(one-w) + mix*w is rewritten as base*one + (mix-base)*w.
  assign diff_s = $signed({1'b0, mix_i}) - $signed({1'b0, base_i});
  assign wt_s   = $signed({1'b0, weight_i});
  assign prod_d = PW'(diff_s) * PW'(wt_s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      base_q <= base_i;
    end
  end

  // The sum is never negative and stays below 256 * one.
  assign sum    = $signed({3'b000, base_q, {FRACTION_BITS{1'b0}}}) + prod_q;
  assign chan_o = sum[FRACTION_BITS+rrb_pkg::CHAN_W-1:FRACTION_BITS];

endmodule
